>>> rtl/core/mhm_pkg.sv
// Shared types and constants for the median height measurement block.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package mhm_pkg;

	// Operation codes of an input word
	localparam logic [1:0] OP_POLL   = 2'd0;
	localparam logic [1:0] OP_SAMPLE = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_MOUNT      = 2'd0;
	localparam logic [1:0] CFG_MIN_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_TIMEOUT    = 2'd2;

	// Configuration reset values
	localparam logic [15:0] MOUNT_RESET      = 16'd300;
	localparam logic [15:0] MIN_HEIGHT_RESET = 16'd30;
	localparam logic [15:0] TIMEOUT_RESET    = 16'd1000;

	// Fewest samples that give a median
	localparam int unsigned MIN_FOR_MEDIAN = 3;
	// Largest value of the samples_used field
	localparam int unsigned USED_SAT = 7;

	typedef struct packed {
		logic accept;     // input word taken this cycle
		logic sort_step;  // run one compare-exchange pass
		logic parity;     // pass parity: pairs starting at even or odd index
		logic med_load;   // capture the median entry
		logic out_load;   // load the result word
	} mhm_cmd_t;

	typedef struct packed {
		logic finish;     // the presented poll ends the running job
	} mhm_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/mhm_ctrl.sv
// Controller of the median height block: sequences the sort passes and the
// result load. Depends on mhm_pkg.
`default_nettype none

module mhm_ctrl #(
	parameter int unsigned MAX_SAMPLES = 5
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  wire              out_stall,
	input  mhm_pkg::mhm_sts_t sts,
	output mhm_pkg::mhm_cmd_t cmd
);
	import mhm_pkg::*;

	localparam int unsigned PW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SORT,
		ST_MED,
		ST_CALC
	} state_t;

	state_t        state_q;
	logic [PW-1:0] pass_q;
	logic          out_valid_q;
	logic          accept;
	logic          out_free;
	logic          last_pass;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign last_pass = (pass_q == PW'(MAX_SAMPLES - 1));
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.accept    = accept;
		cmd.sort_step = (state_q == ST_SORT);
		cmd.parity    = pass_q[0];
		cmd.med_load  = (state_q == ST_MED);
		cmd.out_load  = (state_q == ST_CALC) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pass_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load the result word when the height is ready; drop it once
			// the receiver takes it
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					pass_q <= '0;
					if (accept && sts.finish) begin
						state_q <= ST_SORT;
					end
				end
				ST_SORT: begin
					pass_q <= pass_q + 1'b1;
					if (last_pass) begin
						state_q <= ST_MED;
					end
				end
				ST_MED: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/mhm_dp.sv
// Datapath of the median height block: configuration, job state, sample
// store, transposition sorter and height arithmetic. Depends on mhm_pkg.
`default_nettype none

module mhm_dp #(
	parameter int unsigned MAX_SAMPLES = 5
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire  [1:0]        cfg_index,
	input  wire  [15:0]       cfg_data,
	input  wire  [1:0]        op,
	input  wire  [15:0]       request_id,
	input  wire  [15:0]       done_id,
	input  wire  [15:0]       distance_mm,
	input  wire               range_valid,
	input  mhm_pkg::mhm_cmd_t cmd,
	output mhm_pkg::mhm_sts_t sts,
	output logic [15:0]       job_id,
	output logic [15:0]       height_mm,
	output logic [2:0]        samples_used
);
	import mhm_pkg::*;

	localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned IW = $clog2(MAX_SAMPLES);

	logic [15:0]   mount_q;
	logic [15:0]   min_height_q;
	logic [15:0]   timeout_q;
	logic [15:0]   active_q;
	logic [15:0]   elapsed_q;
	logic [CW-1:0] count_q;
	logic [15:0]   store_q [MAX_SAMPLES];
	logic [15:0]   sort_q  [MAX_SAMPLES];
	logic [15:0]   sort_d  [MAX_SAMPLES];
	logic [CW-1:0] n_q;
	logic [15:0]   job_q;
	logic [15:0]   med_q;
	logic [15:0]   job_id_q;
	logic [15:0]   height_q;
	logic [2:0]    used_q;

	logic          cancel;
	logic [15:0]   act_mid;
	logic          start;
	logic [15:0]   act_new;
	logic [15:0]   el_new;
	logic [CW-1:0] cnt_new;
	logic          fin;
	logic [CW-1:0] mid;
	logic [16:0]   diff;
	logic [CW+2:0] n_w;
	logic          too_few;
	logic [15:0]   height_d;
	logic [2:0]    used_d;

	assign cfg_ready = 1'b1;

	// Poll resolution: cancel, then start, then finish test
	always_comb begin
		cancel  = (active_q != '0) && (request_id != active_q);
		act_mid = cancel ? '0 : active_q;
		start   = (act_mid == '0) && (request_id != '0) && (request_id != done_id);
		act_new = start ? request_id : act_mid;
		el_new  = (cancel || start) ? '0 : elapsed_q;
		cnt_new = (cancel || start) ? '0 : count_q;
		fin     = (act_new != '0) &&
		          ((cnt_new == CW'(MAX_SAMPLES)) || (el_new >= timeout_q));
	end

	assign sts.finish = (op == OP_POLL) && fin;

	// One odd-even transposition pass over the first n_q entries
	always_comb begin
		for (int i = 0; i < MAX_SAMPLES; i++) begin
			sort_d[i] = sort_q[i];
		end
		for (int i = 0; i + 1 < MAX_SAMPLES; i++) begin
			if ((i % 2 == int'(cmd.parity)) && (CW'(i + 1) < n_q) &&
			    (sort_q[i] > sort_q[i + 1])) begin
				sort_d[i]     = sort_q[i + 1];
				sort_d[i + 1] = sort_q[i];
			end
		end
	end

	assign mid = n_q >> 1;

	// Height arithmetic on the captured median
	always_comb begin
		diff    = {1'b0, mount_q} - {1'b0, med_q};
		n_w     = {3'b000, n_q};
		too_few = (n_w < (CW+3)'(MIN_FOR_MEDIAN));
		if (too_few || diff[16] || (diff[15:0] < min_height_q)) begin
			height_d = '0;
		end else begin
			height_d = diff[15:0];
		end
		used_d = (n_w > (CW+3)'(USED_SAT)) ? 3'(USED_SAT) : n_w[2:0];
	end

	// Configuration and job state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mount_q      <= MOUNT_RESET;
			min_height_q <= MIN_HEIGHT_RESET;
			timeout_q    <= TIMEOUT_RESET;
			active_q     <= '0;
			elapsed_q    <= '0;
			count_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MOUNT:      mount_q      <= cfg_data;
					CFG_MIN_HEIGHT: min_height_q <= cfg_data;
					CFG_TIMEOUT:    timeout_q    <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.accept) begin
				case (op)
					OP_SAMPLE: begin
						if ((active_q != '0) && range_valid &&
						    (count_q < CW'(MAX_SAMPLES))) begin
							count_q <= count_q + 1'b1;
						end
					end
					OP_TICK: begin
						if (elapsed_q != '1) begin
							elapsed_q <= elapsed_q + 1'b1;
						end
					end
					OP_POLL: begin
						if (fin) begin
							active_q  <= '0;
							elapsed_q <= '0;
							count_q   <= '0;
						end else begin
							active_q  <= act_new;
							elapsed_q <= el_new;
							count_q   <= cnt_new;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept && (op == OP_SAMPLE) && (active_q != '0) && range_valid &&
		    (count_q < CW'(MAX_SAMPLES))) begin
			store_q[count_q[IW-1:0]] <= distance_mm;
		end
		if (cmd.accept && (op == OP_POLL) && fin) begin
			job_q <= act_new;
			n_q   <= cnt_new;
			for (int i = 0; i < MAX_SAMPLES; i++) begin
				sort_q[i] <= store_q[i];
			end
		end else if (cmd.sort_step) begin
			for (int i = 0; i < MAX_SAMPLES; i++) begin
				sort_q[i] <= sort_d[i];
			end
		end
		if (cmd.med_load) begin
			med_q <= sort_q[mid[IW-1:0]];
		end
		if (cmd.out_load) begin
			job_id_q <= job_q;
			height_q <= height_d;
			used_q   <= used_d;
		end
	end

	assign job_id       = job_id_q;
	assign height_mm    = height_q;
	assign samples_used = used_q;

endmodule

`default_nettype wire

>>> rtl/core/median_height_measurement_unit.sv
// Top level of the median height measurement block: joins controller and
// datapath. Depends on mhm_pkg, mhm_ctrl and mhm_dp.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one word per poll, distance
//   sample or millisecond tick. A word is taken when in_valid is high and
//   in_stall low. Samples, ticks and polls that do not end a job produce
//   nothing. A poll that ends a job loads a copy of the sample store into
//   the sorter, which runs MAX_SAMPLES odd-even compare-exchange passes, one
//   per cycle; the median stage then picks the median and the height stage
//   computes the height. The result word appears on out_valid when the
//   height stage loads it; in_stall is high from the edge that takes that
//   poll until the height stage loads the result word.
//   Output channel (out_valid/out_stall) holds one result word in a register.
//   While the receiver stalls, the word holds and new input words are still
//   taken; a second result waits in the height stage, with in_stall high,
//   until the register frees.
//   Configuration writes (cfg_valid/cfg_ready, always ready) are registered;
//   issue them only while the block is idle.
//   Reset: clears job state and restores mount 300 mm, minimum height 30 mm
//   and timeout 1000 ticks. The sample store is not cleared.
`default_nettype none

module median_height_measurement_unit #(
	parameter int unsigned MAX_SAMPLES = 5
) (
	input  wire         clk,
	input  wire         arst_n,
	// configuration write channel
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [15:0] cfg_data,
	// input channel
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  op,
	input  wire  [15:0] request_id,
	input  wire  [15:0] done_id,
	input  wire  [15:0] distance_mm,
	input  wire         range_valid,
	// output channel
	output logic        out_valid,
	input  wire         out_stall,
	output logic [15:0] job_id,
	output logic [15:0] height_mm,
	output logic [2:0]  samples_used
);
	import mhm_pkg::*;

	mhm_cmd_t cmd;
	mhm_sts_t sts;

	// Sequence the sort passes and the result word handoff
	mhm_ctrl #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hold configuration, job state, samples; sort and compute height
	mhm_dp #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.op           (op),
		.request_id   (request_id),
		.done_id      (done_id),
		.distance_mm  (distance_mm),
		.range_valid  (range_valid),
		.cmd          (cmd),
		.sts          (sts),
		.job_id       (job_id),
		.height_mm    (height_mm),
		.samples_used (samples_used)
	);

	// A finished job always carries a nonzero id
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (job_id != 16'd0))
		else $error("result word with zero job id");

	// A nonzero height needs enough samples for a median
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (height_mm != 16'd0)) |-> (samples_used >= 3'(MIN_FOR_MEDIAN)))
		else $error("nonzero height from too few samples");

	// A new result word only follows a cycle in which input was held off
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result word appeared without a height computation");

endmodule

`default_nettype wire
